### hw/rtl/cts_pkg.sv
`timescale 1ns / 1ps

package cts_pkg;

   localparam int VALUE_WIDTH = 128;
   localparam int COUNT_WIDTH = 16;
   localparam int START_WIDTH = 64;
   localparam int FIELD_WIDTH = 16;

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [START_WIDTH-1:0] start_type;

   // sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_TRIPLE = 4'b0010,
      ST_HALVE  = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   // flags from the shared step unit to the sequencer
   typedef struct packed {
      logic overflow;
      logic below_start;
      logic halved_above_one;
      logic halved_odd;
      logic x_above_peak;
   } alu_status_type;

   function automatic count_type sat_inc(count_type c);
      if (&c) begin
         return c;
      end else begin
         return count_type'(c + 1'b1);
      end
   endfunction

   function automatic logic [FIELD_WIDTH-1:0] clip_field(count_type c);
      if ((c >> FIELD_WIDTH) != '0) begin
         return '1;
      end else begin
         return FIELD_WIDTH'(c);
      end
   endfunction

endpackage

### hw/rtl/collatz_trajectory_stats.sv
`timescale 1ns / 1ps

// Collatz trajectory statistics. A request is taken when start is high while
// busy is low; the block then walks the 3x+1 trajectory of req_start_value on
// a 128-bit value until it reaches 1, using one shared step unit under a small
// sequencer. Each 3x+1 and each halving is a step in its own state, and busy
// stays high through every step and through the done state that follows; a
// start of 0 or 1 goes straight to the done state. An overflow ends the walk
// at the 3x+1 that did not fit, and then reports total_steps as zero. The
// result shows on the rsp_ ports for exactly one cycle with rsp_strobe high
// and must be captured then: it is held only until the next request is taken.
// busy is high during that cycle, so the next request is taken the cycle after.
// When overflow_flag is set all other fields are zero; stop_time and
// stopping_value are zero when has_stop is zero.
module collatz_trajectory_stats (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  cts_pkg::start_type    req_start_value,
   output logic                  rsp_strobe,
   output logic [63:0]           rsp_peak_high,
   output logic [63:0]           rsp_peak_low,
   output logic [15:0]           rsp_total_steps,
   output logic [15:0]           rsp_stop_time,
   output logic [63:0]           rsp_stopping_value,
   output logic                  rsp_has_stop,
   output logic                  rsp_overflow_flag
);
   import cts_pkg::*;

   localparam int WIDE_WIDTH = (VALUE_WIDTH > 128) ? VALUE_WIDTH : 128;

   state_type      state_ff, state_in;
   value_type      x_ff, x_in;
   value_type      peak_ff, peak_in;
   start_type      start_ff, start_in;
   count_type      steps_ff, steps_in;
   count_type      halv_ff, halv_in;
   count_type      stop_time_ff, stop_time_in;
   start_type      stop_val_ff, stop_val_in;
   logic           stop_seen_ff, stop_seen_in;
   logic           ovf_ff, ovf_in;

   value_type      tripled;
   value_type      halved;
   alu_status_type alu_st;
   logic           accept;
   logic [WIDE_WIDTH-1:0] peak_wide;

   cts_alu u_alu (
      .x           (x_ff),
      .peak        (peak_ff),
      .start_value (start_ff),
      .tripled     (tripled),
      .halved      (halved),
      .status      (alu_st)
   );

   assign accept = start && (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      peak_in      = peak_ff;
      start_in     = start_ff;
      steps_in     = steps_ff;
      halv_in      = halv_ff;
      stop_time_in = stop_time_ff;
      stop_val_in  = stop_val_ff;
      stop_seen_in = stop_seen_ff;
      ovf_in       = ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // fresh trajectory
               x_in         = VALUE_WIDTH'(req_start_value);
               peak_in      = VALUE_WIDTH'(req_start_value);
               start_in     = req_start_value;
               steps_in     = '0;
               halv_in      = '0;
               stop_time_in = '0;
               stop_val_in  = '0;
               stop_seen_in = 1'b0;
               ovf_in       = 1'b0;
               if (!(|req_start_value[START_WIDTH-1:1])) begin
                  state_in = ST_DONE;
               end else if (req_start_value[0]) begin
                  state_in = ST_TRIPLE;
               end else begin
                  state_in = ST_HALVE;
               end
            end
         end
         ST_TRIPLE: begin
            if (alu_st.overflow) begin
               ovf_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               // 3x+1 is even and above one: always halve next
               x_in     = tripled;
               steps_in = sat_inc(steps_ff);
               state_in = ST_HALVE;
            end
         end
         ST_HALVE: begin
            // peak only moves after a 3x+1, harmless to check every halving
            if (alu_st.x_above_peak) begin
               peak_in = x_ff;
            end
            x_in     = halved;
            steps_in = sat_inc(steps_ff);
            halv_in  = sat_inc(halv_ff);
            if (!stop_seen_ff && alu_st.below_start) begin
               stop_seen_in = 1'b1;
               stop_time_in = sat_inc(halv_ff);
               stop_val_in  = halved[START_WIDTH-1:0];
            end
            if (!alu_st.halved_above_one) begin
               state_in = ST_DONE;
            end else if (alu_st.halved_odd) begin
               state_in = ST_TRIPLE;
            end else begin
               state_in = ST_HALVE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ovf_ff       <= 1'b0;
         stop_seen_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ovf_ff       <= ovf_in;
         stop_seen_ff <= stop_seen_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      peak_ff      <= peak_in;
      start_ff     <= start_in;
      steps_ff     <= steps_in;
      halv_ff      <= halv_in;
      stop_time_ff <= stop_time_in;
      stop_val_ff  <= stop_val_in;
   end

   // result; rsp_strobe marks the done cycle only
   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_DONE);
   assign peak_wide  = WIDE_WIDTH'(peak_ff);

   assign rsp_peak_high      = ovf_ff ? '0 : peak_wide[127:64];
   assign rsp_peak_low       = ovf_ff ? '0 : peak_wide[63:0];
   assign rsp_total_steps    = ovf_ff ? '0 : clip_field(steps_ff);
   assign rsp_stop_time      = (ovf_ff || !stop_seen_ff) ? '0 : clip_field(stop_time_ff);
   assign rsp_stopping_value = (ovf_ff || !stop_seen_ff) ? '0 : stop_val_ff;
   assign rsp_has_stop       = !ovf_ff && stop_seen_ff;
   assign rsp_overflow_flag  = ovf_ff;

   // done lasts one cycle, then the block is ready again
   a_done_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("result strobe longer than one cycle");

   // a taken request always makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken without going busy");

   // the recorded stop value lies below the start
   a_stop_below: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && stop_seen_ff && !ovf_ff) |-> (stop_val_ff < start_ff))
      else $error("stop value not below start");

   // the peak never falls under the start
   a_peak_ge_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !ovf_ff) |-> (peak_ff >= VALUE_WIDTH'(start_ff)))
      else $error("peak below start");

   // halving count never exceeds the step count
   a_halv_le_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (halv_ff <= steps_ff))
      else $error("more halvings than steps");

endmodule

### hw/rtl/cts_alu.sv
`timescale 1ns / 1ps

// shared step unit: 3x+1 with carry check, halving, and the two compares
module cts_alu (
   input  cts_pkg::value_type      x,
   input  cts_pkg::value_type      peak,
   input  cts_pkg::start_type      start_value,
   output cts_pkg::value_type      tripled,
   output cts_pkg::value_type      halved,
   output cts_pkg::alu_status_type status
);
   import cts_pkg::*;

   logic [VALUE_WIDTH+1:0] sum;
   value_type              start_ext;

   // 3x+1 = x + (2x+1), two guard bits catch the carry out
   assign sum       = (VALUE_WIDTH+2)'(x) + (VALUE_WIDTH+2)'({x, 1'b1});
   assign tripled   = sum[VALUE_WIDTH-1:0];
   assign halved    = x >> 1;
   assign start_ext = VALUE_WIDTH'(start_value);

   assign status.overflow         = |sum[VALUE_WIDTH+1:VALUE_WIDTH];
   assign status.below_start      = halved < start_ext;
   assign status.halved_above_one = |halved[VALUE_WIDTH-1:1];
   assign status.halved_odd       = halved[0];
   assign status.x_above_peak     = x > peak;

endmodule
